// ===== design/recursive_mutex_fifo_handoff_macros.svh =====
// ----------------------------------------------------------------------------
// Recursive mutex assertion macros
// Shorthand for concurrent assertions, reset-qualified, that compile away
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RMFH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define RMFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define RMFH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMFH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/rmfh_pkg.sv =====
// ----------------------------------------------------------------------------
// Recursive mutex package
// Command and status codes, and the control bundle from the controller
// to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rmfh_pkg;

	typedef logic [2:0] status_t;

	localparam logic CMD_LOCK   = 1'b0;
	localparam logic CMD_UNLOCK = 1'b1;

	localparam status_t ST_GRANTED  = 3'd0;
	localparam status_t ST_RECURSED = 3'd1;
	localparam status_t ST_BLOCKED  = 3'd2;
	localparam status_t ST_PARTIAL  = 3'd3;
	localparam status_t ST_FREED    = 3'd4;
	localparam status_t ST_HANDOFF  = 3'd5;
	localparam status_t ST_IGNORED  = 3'd6;
	localparam status_t ST_REFUSED  = 3'd7;

	typedef struct packed {
		logic capture;
		logic exec;
	} rmfh_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rmfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Recursive mutex controller
// Runs the request handshake, sequences each item through capture and
// execute, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfh_ctrl
	import rmfh_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output rmfh_ctrl_t ctrl
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic slot_free;

	assign req_stall = (state_q != S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign ctrl.capture = req_valid && !req_stall;
	assign ctrl.exec = (state_q == S_EXEC) && slot_free;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctrl.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/rmfh_dp.sv =====
// ----------------------------------------------------------------------------
// Recursive mutex datapath
// Holds owner, hold count and the waiter queue, decides each request and
// loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "recursive_mutex_fifo_handoff_macros.svh"

module rmfh_dp
	import rmfh_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 8,
	parameter int COUNT_BITS  = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  rmfh_ctrl_t ctrl,
	input  wire        command,
	input  wire  [7:0] task_id,
	output status_t    status,
	output logic [7:0] woken_task,
	output logic [7:0] owner_now,
	output logic [7:0] count_now,
	output logic [4:0] waiters_now
);

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int USED_W = $clog2(QUEUE_DEPTH + 1);

	logic [TASK_BITS-1:0] mem [QUEUE_DEPTH];
	logic [TASK_BITS-1:0] rd_q;

	logic                  cmd_q;
	logic [TASK_BITS-1:0]  task_q;
	logic [TASK_BITS-1:0]  owner_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      tail_q;
	logic [USED_W-1:0]     used_q;

	status_t    status_q;
	logic [7:0] woken_q;
	logic [7:0] owner_now_q;
	logic [7:0] count_now_q;
	logic [4:0] waiters_q;

	logic [31:0] tid_ext;

	status_t               n_status;
	logic [TASK_BITS-1:0]  n_woken;
	logic [TASK_BITS-1:0]  n_owner;
	logic [COUNT_BITS-1:0] n_count;
	logic [COUNT_BITS-1:0] dec_count;
	logic [PTR_W-1:0]      n_head;
	logic [PTR_W-1:0]      n_tail;
	logic [USED_W-1:0]     n_used;
	logic                  push;
	logic [31:0]           woken_ext;
	logic [31:0]           owner_ext;
	logic [31:0]           count_ext;
	logic [31:0]           used_ext;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign tid_ext = 32'(task_id);
	assign dec_count = count_q - COUNT_BITS'(1);

	always_comb begin
		n_status = ST_IGNORED;
		n_woken = '0;
		n_owner = owner_q;
		n_count = count_q;
		n_head = head_q;
		n_tail = tail_q;
		n_used = used_q;
		push = 1'b0;
		if (task_q == '0) begin
			n_status = ST_IGNORED;
		end else if (cmd_q == CMD_LOCK) begin
			if (count_q == '0) begin
				n_count = COUNT_BITS'(1);
				n_owner = task_q;
				n_status = ST_GRANTED;
			end else if (owner_q == task_q) begin
				if (&count_q) begin
					n_status = ST_REFUSED;
				end else begin
					n_count = count_q + COUNT_BITS'(1);
					n_status = ST_RECURSED;
				end
			end else if (used_q == USED_W'(QUEUE_DEPTH)) begin
				n_status = ST_REFUSED;
			end else begin
				push = 1'b1;
				n_tail = next_slot(tail_q);
				n_used = used_q + USED_W'(1);
				n_status = ST_BLOCKED;
			end
		end else begin
			if (count_q != '0 && owner_q == task_q) begin
				if (dec_count != '0) begin
					n_count = dec_count;
					n_status = ST_PARTIAL;
				end else if (used_q != '0) begin
					n_woken = rd_q;
					n_head = next_slot(head_q);
					n_used = used_q - USED_W'(1);
					n_owner = rd_q;
					n_count = COUNT_BITS'(1);
					n_status = ST_HANDOFF;
				end else begin
					n_owner = '0;
					n_count = '0;
					n_status = ST_FREED;
				end
			end
		end
	end

	assign woken_ext = 32'(n_woken);
	assign owner_ext = 32'(n_owner);
	assign count_ext = 32'(n_count);
	assign used_ext  = 32'(n_used);

	always_ff @(posedge clk) begin
		if (ctrl.exec && push) begin
			mem[tail_q] <= task_q;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= command;
			task_q <= tid_ext[TASK_BITS-1:0];
		end
		if (ctrl.exec) begin
			status_q <= n_status;
			woken_q <= woken_ext[7:0];
			owner_now_q <= owner_ext[7:0];
			count_now_q <= count_ext[7:0];
			waiters_q <= used_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			count_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
		end else if (ctrl.exec) begin
			owner_q <= n_owner;
			count_q <= n_count;
			head_q <= n_head;
			tail_q <= n_tail;
			used_q <= n_used;
		end
	end

	assign status = status_q;
	assign woken_task = woken_q;
	assign owner_now = owner_now_q;
	assign count_now = count_now_q;
	assign waiters_now = waiters_q;

	`RMFH_ASSERT_IMPL(a_used_bound, clk, arst_n, 1'b1, used_q <= USED_W'(QUEUE_DEPTH))
	`RMFH_ASSERT_IMPL(a_owner_iff_held, clk, arst_n, 1'b1, (count_q == '0) == (owner_q == '0))
	`RMFH_ASSERT_IMPL(a_wait_needs_owner, clk, arst_n, used_q != '0, count_q != '0)
	`RMFH_ASSERT_NEXT(a_handoff_count, clk, arst_n, ctrl.exec && n_status == ST_HANDOFF, count_q == COUNT_BITS'(1))

endmodule

`default_nettype wire

// ===== design/recursive_mutex_fifo_handoff.sv =====
// ----------------------------------------------------------------------------
// Recursive mutex with FIFO wait queue
// Lock unit for one mutex: owner, recursion count and a queue of waiters,
// with direct handoff to the oldest waiter on the final unlock.
// ----------------------------------------------------------------------------
// Each request is first captured, while the head of the wait queue, whose
// memory has a registered read port, is read; then it is decided and the
// state updated. A new request is taken while a result still waits in the
// output register, but its execute cycle waits until that register is
// free. Task id zero and unlocks by a non-owner change nothing. A lock that
// would overflow the count or the queue is dropped with status seven.
`default_nettype none

module recursive_mutex_fifo_handoff
	import rmfh_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 8,
	parameter int COUNT_BITS  = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire        command,
	input  wire  [7:0] task_id,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output status_t    status,
	output logic [7:0] woken_task,
	output logic [7:0] owner_now,
	output logic [7:0] count_now,
	output logic [4:0] waiters_now
);

	rmfh_ctrl_t ctrl;

	rmfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctrl      (ctrl)
	);

	rmfh_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_BITS   (TASK_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.command     (command),
		.task_id     (task_id),
		.status      (status),
		.woken_task  (woken_task),
		.owner_now   (owner_now),
		.count_now   (count_now),
		.waiters_now (waiters_now)
	);

endmodule

`default_nettype wire
